[rtl/core/mqsf_pkg.sv]
// Shared types and constants of the multi-query score fusion block.
package mqsf_pkg;

    localparam int DOC_COUNT_DEF = 4096;
    localparam int K_MAX_DEF     = 8;
    localparam int SCORE_W       = 32;
    localparam int DOC_IDX_W     = 12;
    localparam int QCNT_W        = 16;

    typedef enum logic [1:0] {
        CMD_PAIR  = 2'd0,
        CMD_EOQ   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_MAX = 2'd0,
        MODE_SUM = 2'd1,
        MODE_KTH = 2'd2
    } mode_t;

    typedef enum logic {
        REG_MODE = 1'b0,
        REG_K    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]               command;
        logic [DOC_IDX_W-1:0]     doc_index;
        logic signed [SCORE_W-1:0] score_value;
    } in_item_t;

    typedef struct packed {
        logic [DOC_IDX_W-1:0]     out_doc_index;
        logic signed [SCORE_W-1:0] fused_score;
    } out_item_t;

    typedef struct packed {
        logic [1:0]               command;
        logic [DOC_IDX_W-1:0]     doc_index;
        logic signed [SCORE_W-1:0] score_value;
        logic                     doc_ok;
    } q_item_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_WRITE
    } back_state_t;

endpackage

[rtl/core/multi_query_score_fusion_top.sv]
// Top level of the multi-query score fusion block: config registers, front and back ends.

// Fuses per-document Q16.16 scores from several query lists into one store of
// DOC_COUNT rows of K_MAX scores. Commands: score pair, end of query, read, clear.
// Items pass a two-entry queue to a sequencer that does one read-modify-write
// of a document row per in-range pair, in steps pop, row read, update, write;
// a read takes pop, row read and update plus any wait on the result register,
// an end of query or out-of-range pair only the pop. The row read is registered
// and the write has its own step. After reset and after each clear command the
// block sweeps the store to zero, one row a cycle, and pops no queued item
// meanwhile; config writes are always taken.
// K-th mode keeps each row in descending order and reads slot k-1, k clamped to 1..K_MAX.
module multi_query_score_fusion_top #(
    parameter int DOC_COUNT = mqsf_pkg::DOC_COUNT_DEF,
    parameter int K_MAX     = mqsf_pkg::K_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mqsf_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output mqsf_pkg::out_item_t m_payload,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [3:0]          cfg_data
);

    logic [1:0]             mode_reg;
    logic [3:0]             k_reg;
    logic                   q_valid;
    mqsf_pkg::q_item_t      q_item;
    logic                   q_pop;
    mqsf_pkg::back_status_t status;

    // config transfers are accepted every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= mqsf_pkg::MODE_MAX;
            k_reg    <= 4'd1;
        end else if (cfg_valid) begin
            if (cfg_index == mqsf_pkg::REG_MODE) begin
                mode_reg <= cfg_data[1:0];
            end else begin
                k_reg <= cfg_data;
            end
        end
    end

    mqsf_front #(
        .DOC_COUNT(DOC_COUNT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    mqsf_back #(
        .DOC_COUNT(DOC_COUNT),
        .K_MAX    (K_MAX)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_mode (mode_reg),
        .cfg_k    (k_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload),
        .status   (status)
    );

    // no item leaves the queue during the clear sweep
    a_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !status.pop)
        else $error("queue pop during clear sweep");

    // pop only from a non-empty queue
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // a clear command popped starts the sweep
    a_clear_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && (q_item.command == mqsf_pkg::CMD_CLEAR)) |=> status.clearing)
        else $error("clear did not start sweep");

endmodule

[rtl/core/mqsf_front.sv]
// Front end: accepts items, tags document range, two-entry queue to the back end.
module mqsf_front #(
    parameter int DOC_COUNT = mqsf_pkg::DOC_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mqsf_pkg::in_item_t s_payload,
    output logic               q_valid,
    output mqsf_pkg::q_item_t  q_item,
    input  logic               q_pop
);

    mqsf_pkg::q_item_t entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push;
    mqsf_pkg::q_item_t q_in;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        q_in.command     = s_payload.command;
        q_in.doc_index   = s_payload.doc_index;
        q_in.score_value = s_payload.score_value;
        q_in.doc_ok      = (32'(s_payload.doc_index) < 32'(DOC_COUNT));
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= q_in;
        end
    end

endmodule

[rtl/core/mqsf_back.sv]
// Back end: score store memory, read-modify-write sequencer, clear sweep, result register.
module mqsf_back #(
    parameter int DOC_COUNT = mqsf_pkg::DOC_COUNT_DEF,
    parameter int K_MAX     = mqsf_pkg::K_MAX_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             cfg_mode,
    input  logic [3:0]             cfg_k,
    input  logic                   q_valid,
    input  mqsf_pkg::q_item_t      q_item,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output mqsf_pkg::out_item_t    m_payload,
    output mqsf_pkg::back_status_t status
);

    localparam int ADDR_W = (DOC_COUNT > 1) ? $clog2(DOC_COUNT) : 1;
    localparam int SLOT_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int KW     = $clog2(K_MAX + 1);
    localparam int SW     = mqsf_pkg::SCORE_W;
    localparam int ROW_W  = K_MAX * SW;

    mqsf_pkg::back_state_t state_reg, state_next;
    mqsf_pkg::q_item_t     cur_reg;
    logic [ROW_W-1:0]      mem [DOC_COUNT];
    logic [ROW_W-1:0]      rdata_reg;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [ADDR_W-1:0]     clr_reg;
    logic [mqsf_pkg::QCNT_W-1:0] qd_reg;
    logic                  m_valid_reg;
    mqsf_pkg::out_item_t   m_payload_reg, out_next;

    logic [ADDR_W+mqsf_pkg::DOC_IDX_W-1:0] addr_ext;
    logic [ADDR_W-1:0]     addr;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;
    logic                  out_load;
    logic                  out_free;

    logic [7:0]            k_ext;
    logic [KW-1:0]         keff;
    logic [SLOT_W-1:0]     km1;
    logic [SLOT_W-1:0]     pos;
    logic [SLOT_W-1:0]     ins;
    logic signed [SW-1:0]  slot [K_MAX];
    logic signed [SW-1:0]  sval;
    logic signed [SW-1:0]  ins_val;
    logic signed [SW:0]    sum;
    logic                  first_q;

    assign addr_ext = (ADDR_W + mqsf_pkg::DOC_IDX_W)'(cur_reg.doc_index);
    assign addr     = addr_ext[ADDR_W-1:0];
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_payload = m_payload_reg;
    assign status.clearing = (state_reg == mqsf_pkg::ST_CLEAR);
    assign status.pop      = q_pop;

    // effective K and insert slot
    always_comb begin
        k_ext = 8'(cfg_k);
        if (k_ext == 8'd0) begin
            k_ext = 8'd1;
        end else if (k_ext > 8'(K_MAX)) begin
            k_ext = 8'(K_MAX);
        end
        keff = KW'(k_ext);
        km1  = SLOT_W'(k_ext - 8'd1);
        pos  = (32'(qd_reg) < 32'(km1)) ? SLOT_W'(qd_reg) : km1;
        first_q = (qd_reg == '0);
    end

    // row update
    always_comb begin
        for (int i = 0; i < K_MAX; i++) begin
            slot[i] = rdata_reg[i*SW +: SW];
        end
        sval    = cur_reg.score_value;
        row_next = rdata_reg;
        ins_val = '0;
        ins     = '0;
        sum     = {slot[0][SW-1], slot[0]} + {sval[SW-1], sval};
        case (mqsf_pkg::mode_t'(cfg_mode))
            mqsf_pkg::MODE_KTH: begin
                ins_val = ((32'(qd_reg) < 32'(keff)) || (sval > slot[pos])) ? sval : slot[pos];
                // bubble stops below the nearest upper slot that is not smaller
                for (int i = 0; i < K_MAX; i++) begin
                    if ((SLOT_W'(i) < pos) && (slot[i] >= ins_val)) begin
                        ins = SLOT_W'(i + 1);
                    end
                end
                for (int i = 0; i < K_MAX; i++) begin
                    if ((SLOT_W'(i) < ins) || (SLOT_W'(i) > pos)) begin
                        row_next[i*SW +: SW] = slot[i];
                    end else if (SLOT_W'(i) == ins) begin
                        row_next[i*SW +: SW] = ins_val;
                    end else begin
                        row_next[i*SW +: SW] = slot[(i > 0) ? i - 1 : 0];
                    end
                end
            end
            mqsf_pkg::MODE_SUM: begin
                if (first_q) begin
                    row_next[SW-1:0] = sval;
                end else if (sum[SW] != sum[SW-1]) begin
                    row_next[SW-1:0] = sum[SW] ? {1'b1, {(SW-1){1'b0}}}
                                               : {1'b0, {(SW-1){1'b1}}};
                end else begin
                    row_next[SW-1:0] = sum[SW-1:0];
                end
            end
            default: begin
                if (first_q || (sval > slot[0])) begin
                    row_next[SW-1:0] = sval;
                end
            end
        endcase
        out_next.out_doc_index = cur_reg.doc_index;
        if (!cur_reg.doc_ok) begin
            out_next.fused_score = '0;
        end else if (cfg_mode == mqsf_pkg::MODE_KTH) begin
            out_next.fused_score = slot[km1];
        end else begin
            out_next.fused_score = slot[0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mqsf_pkg::ST_CLEAR: begin
                if (clr_reg == ADDR_W'(DOC_COUNT - 1)) begin
                    state_next = mqsf_pkg::ST_IDLE;
                end
            end
            mqsf_pkg::ST_IDLE: begin
                if (q_valid) begin
                    unique case (mqsf_pkg::cmd_t'(q_item.command))
                        mqsf_pkg::CMD_PAIR:  state_next = q_item.doc_ok ? mqsf_pkg::ST_READ
                                                                        : mqsf_pkg::ST_IDLE;
                        mqsf_pkg::CMD_READ:  state_next = mqsf_pkg::ST_READ;
                        mqsf_pkg::CMD_CLEAR: state_next = mqsf_pkg::ST_CLEAR;
                        default:             state_next = mqsf_pkg::ST_IDLE;
                    endcase
                end
            end
            mqsf_pkg::ST_READ: state_next = mqsf_pkg::ST_CALC;
            mqsf_pkg::ST_CALC: begin
                if (cur_reg.command != mqsf_pkg::CMD_READ) begin
                    state_next = mqsf_pkg::ST_WRITE;
                end else if (out_free) begin
                    state_next = mqsf_pkg::ST_IDLE;
                end
            end
            mqsf_pkg::ST_WRITE: state_next = mqsf_pkg::ST_IDLE;
            default:            state_next = mqsf_pkg::ST_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr;
        mem_wdata = row_reg;
        out_load  = 1'b0;
        unique case (state_reg)
            mqsf_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            mqsf_pkg::ST_IDLE:  q_pop = q_valid;
            mqsf_pkg::ST_CALC:  out_load = (cur_reg.command == mqsf_pkg::CMD_READ) && out_free;
            mqsf_pkg::ST_WRITE: mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mqsf_pkg::ST_CLEAR;
            clr_reg     <= '0;
            qd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == mqsf_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end else begin
                clr_reg <= '0;
            end
            if (q_pop && (q_item.command == mqsf_pkg::CMD_CLEAR)) begin
                qd_reg <= '0;
            end else if (q_pop && (q_item.command == mqsf_pkg::CMD_EOQ) && (qd_reg != '1)) begin
                qd_reg <= qd_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_item;
        end
        if (state_reg == mqsf_pkg::ST_CALC) begin
            row_reg <= row_next;
        end
        if (out_load) begin
            m_payload_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[addr];
    end

endmodule

[verif/multi_query_score_fusion_top_tb.sv]
// Self-checking testbench for the multi-query score fusion block.
`timescale 1ns / 1ps

// Scoreboard: holds its own copy of the fused score store, predicts read results.
class fusion_scoreboard;
    logic signed [31:0] rows [0:4095][0:7];
    int unsigned        finished_queries;
    logic [1:0]         mode_raw;
    logic [3:0]         k_raw;
    mqsf_pkg::out_item_t pending_reads [$];
    int                 mismatches;

    function void clear_rows();
        foreach (rows[d, s]) rows[d][s] = '0;
        finished_queries = 0;
    endfunction

    function void set_reg(mqsf_pkg::reg_idx_t idx, logic [3:0] data);
        if (idx == mqsf_pkg::REG_MODE) mode_raw = data[1:0];
        else k_raw = data;
    endfunction

    function int eff_k();
        if (k_raw == 0) return 1;
        if (k_raw > 8) return 8;
        return k_raw;
    endfunction

    function void note_input(mqsf_pkg::in_item_t it);
        int k, pos;
        logic signed [31:0] t;
        logic signed [32:0] sum;
        mqsf_pkg::out_item_t r;
        case (it.command)
            mqsf_pkg::CMD_PAIR: begin
                if (mode_raw == mqsf_pkg::MODE_KTH) begin
                    k = eff_k();
                    pos = (finished_queries < k - 1) ? finished_queries : k - 1;
                    if (finished_queries < k || it.score_value > rows[it.doc_index][pos])
                        rows[it.doc_index][pos] = it.score_value;
                    while (pos != 0 && rows[it.doc_index][pos] > rows[it.doc_index][pos-1]) begin
                        t = rows[it.doc_index][pos-1];
                        rows[it.doc_index][pos-1] = rows[it.doc_index][pos];
                        rows[it.doc_index][pos] = t;
                        pos--;
                    end
                end else if (mode_raw == mqsf_pkg::MODE_SUM) begin
                    if (finished_queries == 0) rows[it.doc_index][0] = it.score_value;
                    else begin
                        sum = rows[it.doc_index][0] + it.score_value;
                        if (sum > 33'sh07FFFFFFF) sum = 33'sh07FFFFFFF;
                        if (sum < -33'sh080000000) sum = -33'sh080000000;
                        rows[it.doc_index][0] = sum[31:0];
                    end
                end else if (finished_queries == 0 || it.score_value > rows[it.doc_index][0])
                    rows[it.doc_index][0] = it.score_value;
            end
            mqsf_pkg::CMD_EOQ: if (finished_queries < 65535) finished_queries++;
            mqsf_pkg::CMD_CLEAR: clear_rows();
            default: begin
                r.out_doc_index = it.doc_index;
                r.fused_score = (mode_raw == mqsf_pkg::MODE_KTH) ?
                    rows[it.doc_index][eff_k()-1] : rows[it.doc_index][0];
                pending_reads.push_back(r);
            end
        endcase
    endfunction

    function void check_result(mqsf_pkg::out_item_t got);
        mqsf_pkg::out_item_t want;
        if (pending_reads.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result doc %0d score %0d",
                got.out_doc_index, got.fused_score);
            return;
        end
        want = pending_reads.pop_front();
        if (got.out_doc_index !== want.out_doc_index || got.fused_score !== want.fused_score) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected doc %0d score %0d, got doc %0d score %0d",
                    want.out_doc_index, want.fused_score, got.out_doc_index, got.fused_score);
        end
    endfunction
endclass

module multi_query_score_fusion_top_tb;

    // A clearing sweep runs after reset and after each clear command.
    localparam int LIMIT_CYCLES = 900000;
    localparam int SWEEP_WAIT   = 4096 + 40;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    mqsf_pkg::in_item_t  s_payload = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    mqsf_pkg::out_item_t m_payload;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = 1'b0;
    logic [3:0]          cfg_data = '0;

    fusion_scoreboard fusion_sb;
    int  cycle_count = 0;
    int  sweep_end = 0;      // cycle by which the latest clear sweep is surely over
    bit  idle_free = 1'b0;   // long stretch without idling on either side

    multi_query_score_fusion_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: random backpressure, check every transfer.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) fusion_sb.check_result(m_payload);
        m_ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 18);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Send one item; optional random gap first. Waits for the transfer.
    // Valid stays up after the transfer so the next item can follow at once;
    // a gap or drain_results drops it.
    task automatic send_item(mqsf_pkg::cmd_t cmd, logic [11:0] doc, logic [31:0] score);
        mqsf_pkg::in_item_t it;
        it.command = cmd;
        it.doc_index = doc;
        it.score_value = score;
        while (!idle_free && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        fusion_sb.note_input(it);
        if (cmd == mqsf_pkg::CMD_CLEAR) sweep_end = cycle_count + SWEEP_WAIT;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (fusion_sb.pending_reads.size() != 0) @(posedge aclk);
        while (cycle_count < sweep_end) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Register writes only with the block quiet.
    task automatic write_reg(mqsf_pkg::reg_idx_t idx, logic [3:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        fusion_sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // Docs drawn mostly from a small pool so rows see several queries.
    function automatic logic [11:0] pick_doc();
        if ($urandom_range(9) < 8) return 12'(($urandom_range(15) * 257) & 12'hFFF);
        return 12'($urandom);
    endfunction

    function automatic logic [31:0] pick_score();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF - $urandom_range(3);
            1: return 32'h80000000 + $urandom_range(3);
            2: return 32'($urandom_range(200000)) - 32'd100000;
            default: return $urandom;
        endcase
    endfunction

    // One fusion phase: several queries of pairs, reads, occasional noise.
    task automatic run_phase(int items);
        int n;
        for (n = 0; n < items; ) begin
            case ($urandom_range(19))
                0, 1: begin send_item(mqsf_pkg::CMD_EOQ, 12'd0, $urandom); n++; end
                2, 3, 4, 5: begin
                    send_item(mqsf_pkg::CMD_READ, pick_doc(), $urandom); n++;
                end
                6: if ($urandom_range(9) == 0) begin
                    send_item(mqsf_pkg::CMD_CLEAR, pick_doc(), $urandom); n++;
                end
                default: begin
                    send_item(mqsf_pkg::CMD_PAIR, pick_doc(), pick_score()); n++;
                end
            endcase
        end
    endtask

    int ph;
    initial begin
        fusion_sb = new();
        fusion_sb.clear_rows();
        fusion_sb.mode_raw = mqsf_pkg::MODE_MAX;
        fusion_sb.k_raw = 4'd1;
        fusion_sb.mismatches = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        sweep_end = cycle_count + SWEEP_WAIT;
        @(posedge aclk);

        // Directed: extremes, every command, never-scored doc, first query overwrite.
        write_reg(mqsf_pkg::REG_MODE, 4'(mqsf_pkg::MODE_SUM));
        send_item(mqsf_pkg::CMD_READ, 12'd4095, 32'd0);
        send_item(mqsf_pkg::CMD_PAIR, 12'd0, 32'h80000000);
        send_item(mqsf_pkg::CMD_PAIR, 12'd4095, 32'h7FFFFFFF);
        send_item(mqsf_pkg::CMD_PAIR, 12'd0, 32'h00010000);   // first query overwrites
        send_item(mqsf_pkg::CMD_EOQ, 12'hFFF, 32'hFFFFFFFF);
        send_item(mqsf_pkg::CMD_PAIR, 12'd4095, 32'h7FFFFFFF); // saturate high
        send_item(mqsf_pkg::CMD_PAIR, 12'd1, 32'h80000000);
        send_item(mqsf_pkg::CMD_EOQ, 12'd0, 32'd0);
        send_item(mqsf_pkg::CMD_PAIR, 12'd1, 32'h80000000);    // saturate low
        send_item(mqsf_pkg::CMD_READ, 12'd4095, 32'hFFFFFFFF);
        send_item(mqsf_pkg::CMD_READ, 12'd1, 32'd0);
        send_item(mqsf_pkg::CMD_READ, 12'd0, 32'd0);
        send_item(mqsf_pkg::CMD_READ, 12'd2, 32'd0);
        write_reg(mqsf_pkg::REG_MODE, 4'(mqsf_pkg::MODE_KTH));
        write_reg(mqsf_pkg::REG_K, 4'd0);
        send_item(mqsf_pkg::CMD_PAIR, 12'd5, 32'h00050000);
        send_item(mqsf_pkg::CMD_READ, 12'd5, 32'd0);
        write_reg(mqsf_pkg::REG_K, 4'd15);
        send_item(mqsf_pkg::CMD_READ, 12'd5, 32'd0);
        send_item(mqsf_pkg::CMD_CLEAR, 12'hABC, 32'h5A5A5A5A);
        send_item(mqsf_pkg::CMD_READ, 12'd4095, 32'd0);
        write_reg(mqsf_pkg::REG_MODE, 4'd3);
        send_item(mqsf_pkg::CMD_PAIR, 12'd7, 32'h12345678);
        send_item(mqsf_pkg::CMD_READ, 12'd7, 32'd0);

        // Random phases over mode/k settings; middle phase runs without idling.
        for (ph = 0; ph < 10; ph++) begin
            write_reg(mqsf_pkg::REG_MODE, (ph == 9) ? 4'd3 : 4'(ph % 3));
            write_reg(mqsf_pkg::REG_K,
                (ph == 2) ? 4'd8 : (ph == 5) ? 4'd1 : 4'($urandom_range(15)));
            if (ph % 4 == 0) send_item(mqsf_pkg::CMD_CLEAR, 12'd0, 32'd0);
            idle_free = (ph == 4);
            run_phase(63);
            if (ph == 6) drain_results(); // sender waits until all results are back
        end
        idle_free = 1'b0;
        drain_results();
        repeat (50) @(posedge aclk);
        if (fusion_sb.mismatches == 0 && fusion_sb.pending_reads.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
